FILE: design/mqd_pkg.sv
// Shared types, codes and default sizes for the bank of priority deques.
package mqd_pkg;

  localparam int NUM_QUEUES_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int ID_WIDTH_DEF    = 16;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  localparam logic [1:0] RES_ADDED    = 2'd0;
  localparam logic [1:0] RES_FULL     = 2'd1;
  localparam logic [1:0] RES_SERVED   = 2'd2;
  localparam logic [1:0] RES_EMPTY    = 2'd3;

  typedef struct packed {
    logic        func;
    logic [3:0]  queue_index;
    logic [15:0] entry_id;
    logic        urgent;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [15:0] served_id;
    logic        served_urgent;
    logic [3:0]  queue_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic done;
  } ctrl_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

FILE: design/multi_queue_two_priority_deque.sv
// Top level of the bank of bounded two-priority deques.
// A command item is taken at a rising edge where start is high and busy is
// low. An add item appends a regular entry at the tail of the addressed
// queue or pushes an urgent entry at its head; a take item pops the head.
// Each queue is a ring in a shared entry memory with its own head pointer
// and length, so an urgent push moves the head back rather than shifting.
// Exactly one result item follows each command: out_strobe is high in the
// done state, which follows the exec state, and the result ports hold the
// code, served id and flag, and the queue length after the command.
// A new command may be accepted in the cycle that shows the result, so one
// can enter before the last result has been taken; busy is high in the exec
// state, in which the memory read of the head entry is registered.
// The receiver cannot hold results off; none are buffered beyond that cycle.
// Reset clears all queue lengths and head pointers and returns to idle;
// busy is held high while reset is asserted. The entry memory is not
// cleared, as only written slots are ever read.
module multi_queue_two_priority_deque import mqd_pkg::*; #(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  ctrl_cmd_t cmd;

  mqd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  mqd_datapath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

FILE: design/mqd_ctrl.sv
// Controller state machine that sequences one command through the datapath.
module mqd_ctrl import mqd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign busy   = (state_r == ST_EXEC) || !rst_n;
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        state_nxt = accept ? ST_EXEC : ST_IDLE;
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign cmd.load = accept;
  assign cmd.exec = (state_r == ST_EXEC);
  assign cmd.done = (state_r == ST_DONE);

endmodule

FILE: design/mqd_datapath.sv
// Datapath: per-queue ring pointers and lengths, entry memory and result registers.
module mqd_datapath import mqd_pkg::*; #(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctrl_cmd_t cmd,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SW    = PW + 1;
  localparam int MEM_N = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = (MEM_N > 1) ? $clog2(MEM_N) : 1;

  logic [QW-1:0] qmap [16];

  for (genvar v = 0; v < 16; v++) begin : g_qmap
    assign qmap[v] = QW'(v % NUM_QUEUES);
  end

  in_item_t cmd_r;

  logic [PW-1:0] head_r [NUM_QUEUES];
  logic [LW-1:0] len_r  [NUM_QUEUES];

  logic [ID_WIDTH:0] mem [MEM_N];
  logic [ID_WIDTH:0] rdata_r;

  logic [1:0]    code_r;
  logic          served_r;
  logic [LW-1:0] count_r;

  logic [QW-1:0]     q;
  logic [PW-1:0]     head;
  logic [LW-1:0]     len;
  logic [SW-1:0]     tail_sum;
  logic [PW-1:0]     tail;
  logic [PW-1:0]     head_dec;
  logic [PW-1:0]     head_inc;
  logic              is_full;
  logic              is_empty;
  logic              do_add;
  logic              do_take;
  logic [PW-1:0]     wslot;
  logic [PW-1:0]     head_nxt;
  logic [LW-1:0]     len_nxt;
  logic [AW-1:0]     qbase;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [ID_WIDTH:0] wdata;
  logic [1:0]        code_nxt;

  assign q    = qmap[cmd_r.queue_index];
  assign head = head_r[q];
  assign len  = len_r[q];

  assign tail_sum = SW'(head) + SW'(len);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : PW'(tail_sum);
  assign head_dec = (head == '0) ? PW'(QUEUE_DEPTH - 1) : PW'(head - PW'(1));
  assign head_inc = (SW'(head) + SW'(1) == SW'(QUEUE_DEPTH)) ? '0 : PW'(head + PW'(1));

  assign is_full  = (len == LW'(QUEUE_DEPTH));
  assign is_empty = (len == '0);
  assign do_add   = cmd.exec && (cmd_r.func == FUNC_ADD) && !is_full;
  assign do_take  = cmd.exec && (cmd_r.func == FUNC_TAKE) && !is_empty;

  always_comb begin
    head_nxt = head;
    len_nxt  = len;
    wslot    = tail;
    code_nxt = RES_ADDED;
    if (cmd_r.func == FUNC_ADD) begin
      if (is_full) begin
        code_nxt = RES_FULL;
      end else begin
        code_nxt = RES_ADDED;
        len_nxt  = len + LW'(1);
        if (cmd_r.urgent) begin
          wslot    = head_dec;
          head_nxt = head_dec;
        end
      end
    end else begin
      if (is_empty) begin
        code_nxt = RES_EMPTY;
      end else begin
        code_nxt = RES_SERVED;
        len_nxt  = len - LW'(1);
        head_nxt = head_inc;
      end
    end
  end

  assign qbase = AW'(q) * AW'(QUEUE_DEPTH);
  assign waddr = qbase + AW'(wslot);
  assign raddr = qbase + AW'(head);
  assign wdata = {cmd_r.urgent, ID_WIDTH'(cmd_r.entry_id)};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        len_r[i]  <= '0;
      end
    end else if (do_add || do_take) begin
      head_r[q] <= head_nxt;
      len_r[q]  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_add) begin
      mem[waddr] <= wdata;
    end
    if (do_take) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      code_r   <= code_nxt;
      served_r <= do_take;
      count_r  <= len_nxt;
    end
  end

  assign out_strobe              = cmd.done;
  assign out_item.result_code    = code_r;
  assign out_item.served_id      = served_r ? 16'(rdata_r[ID_WIDTH-1:0]) : 16'd0;
  assign out_item.served_urgent  = served_r ? rdata_r[ID_WIDTH] : 1'b0;
  assign out_item.queue_count    = 4'(count_r);

endmodule

FILE: tb/tb.sv
// Testbench for the bank of two-priority deques, with a scoreboard that predicts each result.
`timescale 1ns / 100ps

module tb import mqd_pkg::*;;

  localparam int WATCHDOG_LIMIT = 1000;

  class deque_scoreboard;
    logic [15:0] id_cells [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF];
    logic urgent_cells [NUM_QUEUES_DEF][QUEUE_DEPTH_DEF];
    int unsigned fill [NUM_QUEUES_DEF];
    out_item_t awaited [$];
    int unsigned mismatches;

    function new();
      foreach (fill[q]) fill[q] = 0;
      mismatches = 0;
    endfunction

    function void note_command(in_item_t cmd);
      int unsigned q;
      int unsigned len;
      int i;
      out_item_t res;
      q = cmd.queue_index % NUM_QUEUES_DEF;
      len = fill[q];
      res = '0;
      if (cmd.func == FUNC_ADD) begin
        if (len >= QUEUE_DEPTH_DEF) begin
          res.result_code = RES_FULL;
        end else begin
          if (cmd.urgent) begin
            for (i = len; i > 0; i--) begin
              id_cells[q][i] = id_cells[q][i-1];
              urgent_cells[q][i] = urgent_cells[q][i-1];
            end
            id_cells[q][0] = cmd.entry_id;
            urgent_cells[q][0] = 1'b1;
          end else begin
            id_cells[q][len] = cmd.entry_id;
            urgent_cells[q][len] = 1'b0;
          end
          fill[q] = len + 1;
          res.result_code = RES_ADDED;
        end
      end else begin
        if (len == 0) begin
          res.result_code = RES_EMPTY;
        end else begin
          res.served_id = id_cells[q][0];
          res.served_urgent = urgent_cells[q][0];
          for (i = 1; i < len; i++) begin
            id_cells[q][i-1] = id_cells[q][i];
            urgent_cells[q][i-1] = urgent_cells[q][i];
          end
          fill[q] = len - 1;
          res.result_code = RES_SERVED;
        end
      end
      res.queue_count = 4'(fill[q]);
      awaited.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result item with nothing expected: code %h id %h urgent %h count %h",
                   got.result_code, got.served_id, got.served_urgent, got.queue_count);
        return;
      end
      exp = awaited.pop_front();
      if (got.result_code !== exp.result_code || got.served_id !== exp.served_id ||
          got.served_urgent !== exp.served_urgent || got.queue_count !== exp.queue_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected code %h id %h urgent %h count %h, got %h %h %h %h",
                   exp.result_code, exp.served_id, exp.served_urgent, exp.queue_count,
                   got.result_code, got.served_id, got.served_urgent, got.queue_count);
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  deque_scoreboard sb = new();
  int unsigned quiet_cycles = 0;

  multi_queue_two_priority_deque u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_command(in_item);
      if (out_strobe) sb.check_result(out_item);
      if ((start && !busy) || out_strobe) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  function automatic in_item_t make_cmd(logic func, logic [3:0] q, logic [15:0] id,
                                        logic urg);
    in_item_t c;
    c.func = func;
    c.queue_index = q;
    c.entry_id = id;
    c.urgent = urg;
    return c;
  endfunction

  function automatic in_item_t random_cmd(int add_pct, logic [3:0] hot);
    in_item_t c;
    c.func = ($urandom_range(99) < add_pct) ? FUNC_ADD : FUNC_TAKE;
    c.queue_index = ($urandom_range(99) < 75) ? 4'(hot + $urandom_range(1))
                                              : 4'($urandom_range(15));
    c.entry_id = 16'($urandom);
    c.urgent = 1'($urandom_range(1));
    return c;
  endfunction

  task automatic send_command(in_item_t cmd);
    @(negedge clk);
    start <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
    in_item <= $bits(in_item_t)'($urandom);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int idle_pct, int count);
    int k;
    int add_pct;
    logic [3:0] hot;
    add_pct = 50;
    hot = '0;
    for (k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: add_pct = 30;
          1: add_pct = 50;
          default: add_pct = 75;
        endcase
        hot = 4'($urandom_range(15));
      end
      while ($urandom_range(99) < idle_pct) idle_cycle();
      send_command(random_cmd(add_pct, hot));
    end
  endtask

  initial begin
    int i;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_command(make_cmd(FUNC_TAKE, 4'd0, 16'hFFFF, 1'b1));
    send_command(make_cmd(FUNC_ADD, 4'd15, 16'hFFFF, 1'b0));
    send_command(make_cmd(FUNC_ADD, 4'd15, 16'h0000, 1'b1));
    for (i = 0; i < 6; i++)
      send_command(make_cmd(FUNC_ADD, 4'd15, 16'(16'h1111 * (i + 1)), 1'(i % 2)));
    send_command(make_cmd(FUNC_ADD, 4'd15, 16'hA5A5, 1'b1));
    send_command(make_cmd(FUNC_ADD, 4'd15, 16'h5A5A, 1'b0));
    repeat (9) send_command(make_cmd(FUNC_TAKE, 4'd15, 16'h0000, 1'b0));
    send_command(make_cmd(FUNC_ADD, 4'd0, 16'h8001, 1'b1));
    send_command(make_cmd(FUNC_TAKE, 4'd0, 16'h7FFE, 1'b0));
    drain();

    run_phase(35, 230);
    drain();
    run_phase(85, 230);
    drain();
    run_phase(0, 240);
    drain();
    repeat (8) @(negedge clk);

    if (sb.outstanding() != 0)
      $display("expected result items never arrived: %0d", sb.outstanding());
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
